@@ rtl/cfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types, constants and helper functions of the contiguous fit search:
// free-run length doubling step and the pairwise hole selection tree.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // field widths of the request and result items
  localparam int MAP_W  = 64;
  localparam int REQ_W  = 7;
  localparam int POL_W  = 2;
  localparam int IDX_W  = 6;

  // examined part of the bitmap and derived sizes
  localparam int MAP_BITS  = 64;
  localparam int LEN_W     = $clog2(MAP_BITS + 1);
  localparam int NUM_STEPS = $clog2(MAP_BITS);
  localparam int STEPS_A   = NUM_STEPS / 2;
  localparam int LVL_A     = NUM_STEPS / 2;
  localparam int MID_NODES = (MAP_BITS + (1 << LVL_A) - 1) >> LVL_A;

  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_WORST = 2'd1,
    POL_BEST  = 2'd2,
    POL_SPARE = 2'd3
  } policy_t;

  // request fields that ride along with the bitmap work
  typedef struct packed {
    logic [REQ_W-1:0] need;
    policy_t          policy;
  } side_t;

  typedef logic [MAP_BITS-1:0][LEN_W-1:0] len_vec_t;

  // one candidate hole in the selection tree
  typedef struct packed {
    logic             vld;
    logic [LEN_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } node_t;

  typedef node_t [MAP_BITS-1:0] node_vec_t;
  typedef node_t [MID_NODES-1:0] mid_vec_t;

  // doubling step: a run that fills its whole window continues into the next one
  function automatic len_vec_t run_step(len_vec_t l, int span);
    len_vec_t r;
    r = l;
    for (int i = 0; i < MAP_BITS; i++) begin
      if (l[i] == LEN_W'(span) && (i + span) < MAP_BITS) begin
        r[i] = l[i] + l[i+span];
      end
    end
    return r;
  endfunction

  // lower-index node wins unless the upper one is strictly better
  function automatic node_t pick(node_t a, node_t b);
    node_t r;
    r = a;
    if (b.vld && (!a.vld || b.key > a.key)) begin
      r = b;
    end
    return r;
  endfunction

  // one tree level over n live nodes, result packed into the low half
  function automatic node_vec_t reduce_level(node_vec_t nv, int n);
    node_vec_t r;
    r = '0;
    for (int j = 0; j < MAP_BITS / 2; j++) begin
      if ((2 * j + 1) < n) begin
        r[j] = pick(nv[2*j], nv[2*j+1]);
      end else if ((2 * j) < n) begin
        r[j] = nv[2*j];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/cfs_run_len.sv @@
// ----------------------------------------------------------------------------
// cfs_run_len
// Two register stages that compute, for every position, the length of the
// free run starting there, by log-step doubling of the window length.
// ----------------------------------------------------------------------------
module cfs_run_len
  import cfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MAP_W-1:0]    in_map,
  input  side_t               in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MAP_BITS-1:0] out_free,
  output len_vec_t            out_len,
  output side_t               out_side
);

  logic                v1;
  logic [MAP_BITS-1:0] free1;
  len_vec_t            len1;
  side_t               side1;
  logic                v2;
  logic [MAP_BITS-1:0] free2;
  len_vec_t            len2;
  side_t               side2;

  logic                rdy1;
  logic                rdy2;
  logic [MAP_BITS-1:0] free_next;
  len_vec_t            len1_next;
  len_vec_t            len2_next;

  // stall chain
  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // first half of the doubling steps
  always_comb begin
    free_next = ~in_map[MAP_BITS-1:0];
    for (int i = 0; i < MAP_BITS; i++) begin
      len1_next[i] = LEN_W'(free_next[i]);
    end
    for (int k = 0; k < STEPS_A; k++) begin
      len1_next = run_step(len1_next, 1 << k);
    end
  end

  // second half of the doubling steps
  always_comb begin
    len2_next = len1;
    for (int k = STEPS_A; k < NUM_STEPS; k++) begin
      len2_next = run_step(len2_next, 1 << k);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      free1 <= free_next;
      len1  <= len1_next;
      side1 <= in_side;
    end
    if (rdy2 && v1) begin
      free2 <= free1;
      len2  <= len2_next;
      side2 <= side1;
    end
  end

  assign out_valid = v2;
  assign out_free  = free2;
  assign out_len   = len2;
  assign out_side  = side2;

endmodule

@@ rtl/cfs_select.sv @@
// ----------------------------------------------------------------------------
// cfs_select
// Marks hole starts that fit the request, keys them by policy and picks the
// winner through a two-stage registered comparison tree.
// ----------------------------------------------------------------------------
module cfs_select
  import cfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MAP_BITS-1:0] in_free,
  input  len_vec_t            in_len,
  input  side_t               in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic [IDX_W-1:0]    start_position
);

  logic       v3;
  mid_vec_t   mid3;
  logic       v4;
  logic       found4;
  logic [IDX_W-1:0] start4;

  logic       rdy3;
  logic       rdy4;
  node_vec_t  leaf;
  node_vec_t  tree_a;
  node_vec_t  tree_b;
  mid_vec_t   mid_next;
  logic       mid_any;

  // stall chain
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  // leaves: fitting hole starts with a policy key
  always_comb begin
    for (int i = 0; i < MAP_BITS; i++) begin
      leaf[i].idx = IDX_W'(i);
      leaf[i].vld = in_free[i] && (i == 0 || !in_free[(i == 0) ? 0 : i-1])
                    && (in_side.need != '0)
                    && (REQ_W'(in_len[i]) >= in_side.need);
      case (in_side.policy)
        POL_WORST: leaf[i].key = in_len[i];
        POL_BEST:  leaf[i].key = ~in_len[i];
        default:   leaf[i].key = '0;
      endcase
    end
  end

  // lower tree levels
  always_comb begin
    int n;
    n = MAP_BITS;
    tree_a = leaf;
    for (int l = 0; l < LVL_A; l++) begin
      tree_a = reduce_level(tree_a, n);
      n = (n + 1) >> 1;
    end
    mid_next = tree_a[MID_NODES-1:0];
  end

  // upper tree levels
  always_comb begin
    int n;
    n = MID_NODES;
    tree_b = '0;
    tree_b[MID_NODES-1:0] = mid3;
    for (int l = LVL_A; l < NUM_STEPS; l++) begin
      tree_b = reduce_level(tree_b, n);
      n = (n + 1) >> 1;
    end
  end

  // any fitting hole among the middle nodes
  always_comb begin
    mid_any = 1'b0;
    for (int j = 0; j < MID_NODES; j++) begin
      mid_any = mid_any | mid3[j].vld;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
    end
  end

  // stage data, result forced to zero when nothing fits
  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      mid3 <= mid_next;
    end
    if (rdy4 && v3) begin
      found4 <= tree_b[0].vld;
      start4 <= tree_b[0].vld ? tree_b[0].idx : '0;
    end
  end

  assign out_valid      = v4;
  assign found          = found4;
  assign start_position = start4;

  // a fitting hole in the middle level must give a found result
  assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4 && mid_any) |=> (v4 && found4))
    else $error("fitting hole lost in upper tree");

  // no candidates at all must give not found
  assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4 && !mid_any) |=> (v4 && !found4))
    else $error("result found without candidate");

endmodule

@@ rtl/contiguous_fit_search.sv @@
// ----------------------------------------------------------------------------
// contiguous_fit_search
// Pipeline from request accept to result valid: two run-length stages, two
// selection tree stages, the last one being the output register.
// Throughput: one request per cycle when not stalled; a stall holds each full stage.
// Reset: rst clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module contiguous_fit_search
  import cfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // occupancy_map[63:0], request_size[70:64], zero pad
  input  logic [1:0]  s_tuser,   // fit_policy[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // start_position[5:0], zero pad
  output logic        m_tuser    // found[0]
);

  side_t               in_side;
  logic                rl_valid;
  logic                rl_ready;
  logic [MAP_BITS-1:0] rl_free;
  len_vec_t            rl_len;
  side_t               rl_side;
  logic [IDX_W-1:0]    start_position;

  // request fields
  assign in_side.need   = s_tdata[MAP_W +: REQ_W];
  assign in_side.policy = policy_t'(s_tuser);

  // free-run lengths
  cfs_run_len u_run_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_map    (s_tdata[MAP_W-1:0]),
    .in_side   (in_side),
    .out_valid (rl_valid),
    .out_ready (rl_ready),
    .out_free  (rl_free),
    .out_len   (rl_len),
    .out_side  (rl_side)
  );

  // hole choice
  cfs_select u_select (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (rl_valid),
    .in_ready       (rl_ready),
    .in_free        (rl_free),
    .in_len         (rl_len),
    .in_side        (rl_side),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .found          (m_tuser),
    .start_position (start_position)
  );

  assign m_tdata = {{(8 - IDX_W){1'b0}}, start_position};

  // an empty output stage means nothing downstream can block a request
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("request blocked with empty output");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a request taken into an empty pipeline shows up after the full latency
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid && !rl_valid) ##1 m_tready ##1 m_tready
      ##1 m_tready |=> m_tvalid)
    else $error("result missing after pipeline latency");

  // a not-found result carries a zero start
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (start_position == '0))
    else $error("nonzero start without a hole");

endmodule
